[rtl/core/esst_pkg.sv]
package esst_pkg;

	// Width of the tick counters; all counter logic follows from it (8 to 32).
	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [CFG_W-1:0]      cfg_t;

	typedef enum logic [2:0] {
		REG_SPEED_MAX         = 3'd0,
		REG_SPEED_MIN         = 3'd1,
		REG_ACCEL_TARGET      = 3'd2,
		REG_THROTTLE_INTERVAL = 3'd3,
		REG_INITIAL_INTERVAL  = 3'd4,
		REG_RETRY_WAIT        = 3'd5
	} reg_idx_t;

	localparam logic [3:0] MODE_IDLE_OFF   = 4'd0;
	localparam logic [3:0] MODE_SWITCH_ON  = 4'd1;
	localparam logic [3:0] MODE_START      = 4'd2;
	localparam logic [3:0] MODE_CRANK      = 4'd3;
	localparam logic [3:0] MODE_STABILIZE  = 4'd4;
	localparam logic [3:0] MODE_THROTTLE   = 4'd5;
	localparam logic [3:0] MODE_COAST      = 4'd6;
	localparam logic [3:0] MODE_KILL       = 4'd7;
	localparam logic [3:0] MODE_SHUTDOWN   = 4'd8;
	localparam logic [3:0] MODE_CRANK_WAIT = 4'd9;
	localparam logic [3:0] MODE_KILL_WAIT  = 4'd10;

	typedef enum logic [10:0] {
		ST_IDLE_OFF   = 11'b000_0000_0001,
		ST_SWITCH_ON  = 11'b000_0000_0010,
		ST_START      = 11'b000_0000_0100,
		ST_CRANK      = 11'b000_0000_1000,
		ST_STABILIZE  = 11'b000_0001_0000,
		ST_THROTTLE   = 11'b000_0010_0000,
		ST_COAST      = 11'b000_0100_0000,
		ST_KILL       = 11'b000_1000_0000,
		ST_SHUTDOWN   = 11'b001_0000_0000,
		ST_CRANK_WAIT = 11'b010_0000_0000,
		ST_KILL_WAIT  = 11'b100_0000_0000
	} state_t;

	function automatic logic [3:0] mode_code(input state_t st);
		logic [3:0] code;
		unique case (st)
			ST_IDLE_OFF:   code = MODE_IDLE_OFF;
			ST_SWITCH_ON:  code = MODE_SWITCH_ON;
			ST_START:      code = MODE_START;
			ST_CRANK:      code = MODE_CRANK;
			ST_STABILIZE:  code = MODE_STABILIZE;
			ST_THROTTLE:   code = MODE_THROTTLE;
			ST_COAST:      code = MODE_COAST;
			ST_KILL:       code = MODE_KILL;
			ST_SHUTDOWN:   code = MODE_SHUTDOWN;
			ST_CRANK_WAIT: code = MODE_CRANK_WAIT;
			ST_KILL_WAIT:  code = MODE_KILL_WAIT;
			default:       code = MODE_IDLE_OFF;
		endcase
		return code;
	endfunction

endpackage

[rtl/core/esst_ifs.sv]
// Tick channel: one sampled millisecond of vehicle status.
interface esst_tick_if;
	logic               valid;
	logic               ready;
	logic               switch_disabled;
	logic               engine_running;
	logic        [15:0] speed;
	logic signed [15:0] accel;
	logic               attempt_ok;

	modport source (output valid, switch_disabled, engine_running, speed, accel, attempt_ok,
		input ready);
	modport sink (input valid, switch_disabled, engine_running, speed, accel, attempt_ok,
		output ready);
endinterface

// Command channel: new state and one-tick command pulses.
interface esst_cmd_if;
	logic       valid;
	logic       ready;
	logic [3:0] mode;
	logic       servo_up;
	logic       servo_down;
	logic       crank_cmd;
	logic       kill_cmd;

	modport source (output valid, mode, servo_up, servo_down, crank_cmd, kill_cmd,
		input ready);
	modport sink (input valid, mode, servo_up, servo_down, crank_cmd, kill_cmd,
		output ready);
endinterface

[rtl/core/engine_start_stop_throttle_fsm_top.sv]
// Engine start-stop throttle sequencer. Every transfer on the tick channel is one
// millisecond of sampled status (enable switch, engine running, speed, acceleration,
// result of this tick's crank or kill attempt) and yields exactly one transfer on the
// command channel carrying the new state and the servo, crank and kill pulses for that
// tick. The sequencer waits for the switch, cranks the engine, steps the throttle servo
// up during start, then holds acceleration near the target until maximum speed, kills
// the engine and coasts down to minimum speed before starting over; failed cranks or
// kills wait retry_wait ticks. A tick is first captured in the input register and then
// sits in the result register, which offers its result on the command channel until
// it is taken. A new tick is taken in every cycle as long as the command channel keeps
// up; the rate is one tick per cycle, set by the combinational next-state logic between
// the two registers. Thresholds and intervals sit in six 16-bit registers on the APB
// port at byte addresses 0, 4, 8, 12, 16 and 20, and should be changed only while no
// tick is in flight.
module engine_start_stop_throttle_fsm_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [esst_pkg::PADDR_W-1:0]   paddr,
	input  logic [esst_pkg::PDATA_W-1:0]   pwdata,
	output logic [esst_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	esst_tick_if.sink                      tick,
	esst_cmd_if.source                     cmd
);
	import esst_pkg::*;

	localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};

	// Configuration registers.
	cfg_t speed_max_q;
	cfg_t speed_min_q;
	cfg_t accel_target_q;
	cfg_t throttle_interval_q;
	cfg_t initial_interval_q;
	cfg_t retry_wait_q;

	reg_idx_t reg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[4:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_max_q         <= CFG_W'(480);
			speed_min_q         <= CFG_W'(80);
			accel_target_q      <= CFG_W'(128);
			throttle_interval_q <= CFG_W'(100);
			initial_interval_q  <= CFG_W'(1);
			retry_wait_q        <= CFG_W'(3000);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SPEED_MAX:         speed_max_q         <= pwdata[CFG_W-1:0];
				REG_SPEED_MIN:         speed_min_q         <= pwdata[CFG_W-1:0];
				REG_ACCEL_TARGET:      accel_target_q      <= pwdata[CFG_W-1:0];
				REG_THROTTLE_INTERVAL: throttle_interval_q <= pwdata[CFG_W-1:0];
				REG_INITIAL_INTERVAL:  initial_interval_q  <= pwdata[CFG_W-1:0];
				REG_RETRY_WAIT:        retry_wait_q        <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Reads of the unused addresses return zero.
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_SPEED_MAX:         prdata = PDATA_W'(speed_max_q);
			REG_SPEED_MIN:         prdata = PDATA_W'(speed_min_q);
			REG_ACCEL_TARGET:      prdata = PDATA_W'(accel_target_q);
			REG_THROTTLE_INTERVAL: prdata = PDATA_W'(throttle_interval_q);
			REG_INITIAL_INTERVAL:  prdata = PDATA_W'(initial_interval_q);
			REG_RETRY_WAIT:        prdata = PDATA_W'(retry_wait_q);
			default:               prdata = '0;
		endcase
	end

	// Stage 1: input register. It advances whenever the result register is free or
	// being emptied in the same cycle, so while a result is stalled one further tick
	// can still be captured before the tick channel is held off.
	logic               valid_s1;
	logic               sw_off_s1;
	logic               running_s1;
	logic        [15:0] speed_s1;
	logic signed [15:0] accel_s1;
	logic               ok_s1;

	logic               valid_s2;
	logic               advance;

	assign advance    = valid_s1 && (!valid_s2 || cmd.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			sw_off_s1  <= tick.switch_disabled;
			running_s1 <= tick.engine_running;
			speed_s1   <= tick.speed;
			accel_s1   <= tick.accel;
			ok_s1      <= tick.attempt_ok;
		end
	end

	// Sequencer state. It is updated only when a tick leaves stage 1, so ticks are
	// evaluated strictly in order.
	state_t state_q;
	timer_t throttle_timer_q;
	timer_t initial_timer_q;
	timer_t wait_timer_q;

	state_t state_nxt;
	timer_t throttle_timer_nxt;
	timer_t initial_timer_nxt;
	timer_t wait_timer_nxt;
	timer_t t_el;
	timer_t i_el;
	timer_t w_el;
	logic   throttle_due;
	logic   initial_due;
	logic   wait_done;
	logic   up;
	logic   down;
	logic   crank;
	logic   kill;

	// Each counter includes the current tick and saturates at its maximum.
	assign t_el = (throttle_timer_q == TIMER_MAX) ? TIMER_MAX : throttle_timer_q + 1'b1;
	assign i_el = (initial_timer_q == TIMER_MAX) ? TIMER_MAX : initial_timer_q + 1'b1;
	assign w_el = (wait_timer_q == TIMER_MAX) ? TIMER_MAX : wait_timer_q + 1'b1;

	// Compare at the wider of the two widths so that a short counter never reaches
	// an interval above its maximum.
	assign throttle_due = CMP_W'(t_el) >= CMP_W'(throttle_interval_q);
	assign initial_due  = CMP_W'(i_el) >= CMP_W'(initial_interval_q);
	assign wait_done    = CMP_W'(w_el) >= CMP_W'(retry_wait_q);

	always_comb begin
		state_nxt          = state_q;
		throttle_timer_nxt = t_el;
		initial_timer_nxt  = i_el;
		up                 = 1'b0;
		down               = 1'b0;
		crank              = 1'b0;
		kill               = 1'b0;
		unique case (state_q)
			ST_SWITCH_ON: begin
				state_nxt = sw_off_s1 ? ST_SHUTDOWN : ST_START;
			end
			ST_START: begin
				if (sw_off_s1) begin
					state_nxt = ST_SHUTDOWN;
				end else if (!running_s1) begin
					state_nxt = ST_CRANK;
				end else if (initial_due) begin
					up                = 1'b1;
					initial_timer_nxt = '0;
					state_nxt         = ST_START;
				end else begin
					state_nxt = ST_STABILIZE;
				end
			end
			ST_CRANK: begin
				if (sw_off_s1) begin
					state_nxt = ST_SHUTDOWN;
				end else if (!running_s1) begin
					crank     = 1'b1;
					state_nxt = ok_s1 ? ST_START : ST_CRANK_WAIT;
				end else begin
					state_nxt = ST_START;
				end
			end
			ST_STABILIZE: begin
				if (sw_off_s1) begin
					state_nxt = ST_SHUTDOWN;
				end else if (!running_s1) begin
					state_nxt = ST_START;
				end else begin
					state_nxt = ST_THROTTLE;
				end
			end
			ST_THROTTLE: begin
				if (sw_off_s1) begin
					state_nxt = ST_SHUTDOWN;
				end else if (speed_s1 >= speed_max_q) begin
					state_nxt = ST_COAST;
				end else begin
					// Between adjustments the state holds with no pulse.
					if (throttle_due) begin
						if (accel_s1 < $signed(accel_target_q)) begin
							up = 1'b1;
						end else begin
							down = 1'b1;
						end
						throttle_timer_nxt = '0;
					end
					state_nxt = ST_THROTTLE;
				end
			end
			ST_COAST: begin
				if (sw_off_s1) begin
					state_nxt = ST_SHUTDOWN;
				end else if (running_s1) begin
					state_nxt = ST_KILL;
				end else if (speed_s1 >= speed_min_q) begin
					state_nxt = ST_COAST;
				end else begin
					state_nxt = ST_IDLE_OFF;
				end
			end
			ST_KILL: begin
				if (sw_off_s1) begin
					state_nxt = ST_SHUTDOWN;
				end else begin
					kill      = 1'b1;
					state_nxt = ok_s1 ? ST_COAST : ST_KILL_WAIT;
				end
			end
			ST_SHUTDOWN: begin
				kill      = 1'b1;
				state_nxt = ok_s1 ? ST_IDLE_OFF : ST_KILL_WAIT;
			end
			ST_CRANK_WAIT: begin
				if (wait_done) begin
					state_nxt = sw_off_s1 ? ST_IDLE_OFF : ST_CRANK;
				end else begin
					state_nxt = ST_CRANK_WAIT;
				end
			end
			ST_KILL_WAIT: begin
				state_nxt = wait_done ? ST_IDLE_OFF : ST_KILL_WAIT;
			end
			default: begin
				state_nxt = sw_off_s1 ? ST_IDLE_OFF : ST_SWITCH_ON;
			end
		endcase
	end

	// The wait counter runs only while staying in a fail-wait state and restarts on
	// every entry.
	always_comb begin
		wait_timer_nxt = '0;
		if ((state_nxt == ST_CRANK_WAIT || state_nxt == ST_KILL_WAIT) &&
			state_nxt == state_q) begin
			wait_timer_nxt = w_el;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE_OFF;
			throttle_timer_q <= '0;
			initial_timer_q  <= '0;
			wait_timer_q     <= '0;
		end else if (advance) begin
			state_q          <= state_nxt;
			throttle_timer_q <= throttle_timer_nxt;
			initial_timer_q  <= initial_timer_nxt;
			wait_timer_q     <= wait_timer_nxt;
		end
	end

	// Stage 2: result register, held until the command channel takes it.
	logic [3:0] mode_s2;
	logic       up_s2;
	logic       down_s2;
	logic       crank_s2;
	logic       kill_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (cmd.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2  <= mode_code(state_nxt);
			up_s2    <= up;
			down_s2  <= down;
			crank_s2 <= crank;
			kill_s2  <= kill;
		end
	end

	assign cmd.valid      = valid_s2;
	assign cmd.mode       = mode_s2;
	assign cmd.servo_up   = up_s2;
	assign cmd.servo_down = down_s2;
	assign cmd.crank_cmd  = crank_s2;
	assign cmd.kill_cmd   = kill_s2;

endmodule

[rtl/core/esst_chk.sv]
module esst_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic [3:0] mode,
	input logic       servo_up,
	input logic       servo_down,
	input logic       crank_cmd,
	input logic       kill_cmd
);
	import esst_pkg::*;

	// A stalled result keeps its contents.
	a_cmd_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_ready |=> cmd_valid && $stable(mode) && $stable(servo_up) &&
		$stable(servo_down) && $stable(crank_cmd) && $stable(kill_cmd))
		else $error("command changed while stalled");

	// The servo is never stepped both ways on one tick.
	a_servo_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> !(servo_up && servo_down))
		else $error("servo up and down on the same tick");

	// Servo steps happen only while starting or throttling.
	a_servo_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && (servo_up || servo_down) |-> mode == MODE_START || mode == MODE_THROTTLE)
		else $error("servo pulse outside start or throttle");

	// A crank leads to start on success or to the crank retry wait.
	a_crank_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && crank_cmd |-> !kill_cmd &&
		(mode == MODE_START || mode == MODE_CRANK_WAIT))
		else $error("crank pulse with unexpected next state");

	// A kill leads to coast, idle or the kill retry wait.
	a_kill_mode: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && kill_cmd |-> !servo_up && !servo_down &&
		(mode == MODE_COAST || mode == MODE_IDLE_OFF || mode == MODE_KILL_WAIT))
		else $error("kill pulse with unexpected next state");

endmodule

bind engine_start_stop_throttle_fsm_top esst_chk u_esst_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.mode       (cmd.mode),
	.servo_up   (cmd.servo_up),
	.servo_down (cmd.servo_down),
	.crank_cmd  (cmd.crank_cmd),
	.kill_cmd   (cmd.kill_cmd)
);
